FILE: rtl/core/dse_pkg.sv
// Shared types and constants for the descending sort engine.
// No dependencies.
package dse_pkg;

  localparam int DATA_W           = 32;
  localparam int MAX_ELEMENTS_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     truncated;
  } out_beat_t;

endpackage

FILE: rtl/core/descending_sort_engine.sv
// Descending sort engine: collects a set of values and drains it largest first.
// Depends on dse_pkg for the beat types and default capacity.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready   | dse_pkg::in_beat_t
//   out     | output    | out_valid/out_ready | dse_pkg::out_beat_t
//
// Each accepted value is inserted into a sorted list held in one RAM with a
// registered read; insertion walks down the list, one entry moved per cycle
// (a value is written directly into an empty list, or dropped when full).
// Draining each beat is a RAM read, then a load of the output register.
// Reset (rst_n low, synchronous) empties the set; the RAM itself is not
// cleared. Output stalls hold the drain; input waits while busy.
module descending_sort_engine #(
  parameter int MAX_ELEMENTS = dse_pkg::MAX_ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dse_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dse_pkg::out_beat_t out_data
);
  import dse_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_ERD   = 3'd3;
  localparam logic [2:0] S_ELD   = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic        ovf_r, ovf_nxt;
  logic        pend_last_r, pend_last_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_r, out_nxt;

  // Sorted element list, largest at index zero.
  logic signed [DATA_W-1:0] mem [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] rdata_r;
  logic        we, re;
  logic [AW-1:0] waddr, raddr;
  logic signed [DATA_W-1:0] wdata;

  logic accept, full, above, k_last;

  assign in_ready  = (state_r == S_LOAD);
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == MAX_C);
  assign above     = key_r > rdata_r;
  assign k_last    = (CW'(k_r) + CW'(1)) == count_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Memory ports: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Control: insertion walk, then drain.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    pend_last_nxt = pend_last_r;
    key_nxt       = key_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = j_r;
    wdata         = key_r;
    re            = 1'b0;
    raddr         = k_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (accept) begin
          pend_last_nxt = in_data.last_in;
          k_nxt         = '0;
          if (full) begin
            ovf_nxt = 1'b1;
            if (in_data.last_in) begin
              state_nxt = S_ERD;
            end
          end else if (count_r == '0) begin
            we        = 1'b1;
            waddr     = '0;
            wdata     = in_data.value;
            count_nxt = CW'(1);
            if (in_data.last_in) begin
              state_nxt = S_ERD;
            end
          end else begin
            key_nxt   = in_data.value;
            j_nxt     = count_r[AW-1:0];
            re        = 1'b1;
            raddr     = AW'(count_r - CW'(1));
            state_nxt = S_INS;
          end
        end
      end
      S_INS: begin
        we = 1'b1;
        waddr = j_r;
        if (above) begin
          // Move the smaller entry down one place and keep walking.
          wdata = rdata_r;
          if (j_r == AW'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            re    = 1'b1;
            raddr = j_r - AW'(2);
            j_nxt = j_r - AW'(1);
          end
        end else begin
          wdata     = key_r;
          count_nxt = count_r + CW'(1);
          state_nxt = pend_last_r ? S_ERD : S_LOAD;
        end
      end
      S_PLACE: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = key_r;
        count_nxt = count_r + CW'(1);
        state_nxt = pend_last_r ? S_ERD : S_LOAD;
      end
      S_ERD: begin
        re        = 1'b1;
        raddr     = k_r;
        state_nxt = S_ELD;
      end
      S_ELD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_nxt.sorted_value = rdata_r;
          out_nxt.last_out     = k_last;
          out_nxt.truncated    = ovf_r;
          if (k_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_last_r <= pend_last_nxt;
    key_r       <= key_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    out_r       <= out_nxt;
  end

  // The fill count never passes capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_C)
    else $error("element count above capacity");

  // The insertion walk never points at the head entry.
  a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (j_r != '0))
    else $error("insertion walk index reached zero");

  // The drain index stays inside the stored set.
  a_drain_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ELD) |-> (CW'(k_r) < count_r))
    else $error("drain index beyond stored set");

  // A final beat leaves the block empty and ready for a new set.
  a_final_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ELD && k_last && (!out_valid_r || out_ready))
      |=> (count_r == '0 && in_ready))
    else $error("set not cleared after final beat");

endmodule
